[sv/rid_pkg.sv]
`timescale 1ns / 1ps
// shared constants, codes and types of the request id translation table
// no dependencies

package rid_pkg;

  localparam int SLOTS  = 32;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);

  localparam logic [15:0] TIMEOUT_RESET = 16'd5;
  localparam logic [31:0] TIME_MAX      = 32'hFFFF_FFFF;

  localparam logic [1:0] REQ_TICK    = 2'd0;
  localparam logic [1:0] REQ_ALLOC   = 2'd1;
  localparam logic [1:0] REQ_RESOLVE = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_BAD_ID = 2'd2;

  typedef enum logic [2:0] {
    RES_ZERO,
    RES_ALLOC,
    RES_FULL,
    RES_BAD,
    RES_RESOLVE
  } res_sel_e;

  typedef struct packed {
    logic [15:0] orig_id;
    logic [31:0] client_ip;
    logic [15:0] client_port;
    logic [31:0] expiry;
  } slot_t;

  typedef struct packed {
    logic              load_req;
    logic              tick;
    logic              rd_en;
    logic              rd_scan;
    logic [SLOT_W-1:0] scan_addr;
    logic              claim;
    logic              mark_done;
    logic              load_res;
    res_sel_e          res_sel;
    logic              load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       bad_id;
    logic       hit;
  } ctl_sts_t;

endpackage

[sv/rid_ram.sv]
`timescale 1ns / 1ps
// generic single port write, single port read ram with registered read
// no dependencies

module rid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                          clk_i,
  input  logic                                          wr_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                              wr_data_i,
  input  logic                                          rd_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                              rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[sv/rid_datapath.sv]
`timescale 1ns / 1ps
// datapath: time counter, timeout register, slot flags, slot ram and result registers
// depends on rid_pkg and rid_ram

module rid_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  input  logic [1:0]        req_type_i,
  input  logic [15:0]       txn_id_i,
  input  logic [31:0]       client_ip_i,
  input  logic [15:0]       client_port_i,
  input  rid_pkg::ctl_cmd_t cmd_i,
  output rid_pkg::ctl_sts_t sts_o,
  output logic [1:0]        status_o,
  output logic [15:0]       new_id_o,
  output logic [15:0]       orig_id_o,
  output logic [31:0]       client_ip_out_o,
  output logic [15:0]       client_port_out_o
);

  import rid_pkg::*;

  logic [1:0]        req_q;
  logic [15:0]       id_q;
  logic [31:0]       ip_q;
  logic [15:0]       port_q;
  logic [31:0]       time_q;
  logic [15:0]       timeout_q;
  logic [SLOTS-1:0]  done_q;
  logic [SLOTS-1:0]  wr_q;
  logic [SLOT_W-1:0] idx_q;

  logic [SLOT_W-1:0] rd_addr;
  slot_t             rd_slot;
  slot_t             eff_slot;
  slot_t             wr_slot;
  logic [32:0]       exp_sum;
  logic [31:0]       new_exp;
  logic              reusable;

  logic [1:0]  res_status_q, res_status_d;
  logic [15:0] res_new_id_q, res_new_id_d;
  logic [15:0] res_orig_q, res_orig_d;
  logic [31:0] res_ip_q, res_ip_d;
  logic [15:0] res_port_q, res_port_d;

  logic [1:0]  out_status_q;
  logic [15:0] out_new_id_q;
  logic [15:0] out_orig_q;
  logic [31:0] out_ip_q;
  logic [15:0] out_port_q;

  assign rd_addr = cmd_i.rd_scan ? cmd_i.scan_addr : SLOT_W'(id_q - 16'd1);

  rid_ram #(
    .WIDTH($bits(slot_t)),
    .DEPTH(SLOTS)
  ) u_slot_ram (
    .clk_i    (clk_i),
    .wr_en_i  (cmd_i.claim),
    .wr_addr_i(idx_q),
    .wr_data_i(wr_slot),
    .rd_en_i  (cmd_i.rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_slot)
  );

  // never written slots read as zero
  assign eff_slot = wr_q[idx_q] ? rd_slot : '0;
  assign reusable = done_q[idx_q] ||
                    ((eff_slot.expiry != 32'd0) && (eff_slot.expiry < time_q));

  assign exp_sum = {1'b0, time_q} + 33'(timeout_q);
  assign new_exp = exp_sum[32] ? TIME_MAX : exp_sum[31:0];

  always_comb begin
    wr_slot.orig_id     = id_q;
    wr_slot.client_ip   = ip_q;
    wr_slot.client_port = port_q;
    wr_slot.expiry      = new_exp;
  end

  assign sts_o.req_type = req_q;
  assign sts_o.bad_id   = (id_q == 16'd0) || (id_q > 16'(SLOTS));
  assign sts_o.hit      = reusable && ((16'(idx_q) + 16'd1) != id_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q    <= '0;
      timeout_q <= TIMEOUT_RESET;
      done_q    <= '1;
      wr_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      if (cmd_i.tick && (time_q != TIME_MAX)) begin
        time_q <= time_q + 32'd1;
      end
      if (cmd_i.claim) begin
        done_q[idx_q] <= 1'b0;
        wr_q[idx_q]   <= 1'b1;
      end
      if (cmd_i.mark_done) begin
        done_q[idx_q] <= 1'b1;
      end
    end
  end

  always_comb begin
    res_status_d = ST_OK;
    res_new_id_d = '0;
    res_orig_d   = '0;
    res_ip_d     = '0;
    res_port_d   = '0;
    case (cmd_i.res_sel)
      RES_ZERO: begin
      end
      RES_ALLOC: begin
        res_new_id_d = 16'(idx_q) + 16'd1;
      end
      RES_FULL: begin
        res_status_d = ST_FULL;
      end
      RES_BAD: begin
        res_status_d = ST_BAD_ID;
      end
      RES_RESOLVE: begin
        res_orig_d = eff_slot.orig_id;
        res_ip_d   = eff_slot.client_ip;
        res_port_d = eff_slot.client_port;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q  <= req_type_i;
      id_q   <= txn_id_i;
      ip_q   <= client_ip_i;
      port_q <= client_port_i;
    end
    if (cmd_i.rd_en) begin
      idx_q <= rd_addr;
    end
    if (cmd_i.load_res) begin
      res_status_q <= res_status_d;
      res_new_id_q <= res_new_id_d;
      res_orig_q   <= res_orig_d;
      res_ip_q     <= res_ip_d;
      res_port_q   <= res_port_d;
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_new_id_q <= res_new_id_q;
      out_orig_q   <= res_orig_q;
      out_ip_q     <= res_ip_q;
      out_port_q   <= res_port_q;
    end
  end

  assign status_o          = out_status_q;
  assign new_id_o          = out_new_id_q;
  assign orig_id_o         = out_orig_q;
  assign client_ip_out_o   = out_ip_q;
  assign client_port_out_o = out_port_q;

endmodule

[sv/rid_ctrl.sv]
`timescale 1ns / 1ps
// controller: request sequencing, slot scan counter and output handshake
// depends on rid_pkg

module rid_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  rid_pkg::ctl_sts_t sts_i,
  output rid_pkg::ctl_cmd_t cmd_o
);

  import rid_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_RRES = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             chk_q, chk_d;
  logic             out_valid_q, out_valid_d;
  logic             scan_end;
  logic             found;
  logic             issue;
  logic             out_free;

  assign scan_end = (cnt_q == CNT_W'(SLOTS));
  assign found    = chk_q && sts_i.hit;
  assign issue    = !scan_end && !found;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d         = state_q;
    cnt_d           = cnt_q;
    chk_d           = 1'b0;
    out_valid_d     = out_valid_q && out_stall_i;
    cmd_o           = '0;
    cmd_o.res_sel   = RES_ZERO;
    cmd_o.scan_addr = cnt_q[SLOT_W-1:0];
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_DISP;
        end
      end
      S_DISP: begin
        cnt_d = '0;
        case (sts_i.req_type)
          REQ_TICK: begin
            cmd_o.tick     = 1'b1;
            cmd_o.load_res = 1'b1;
            state_d        = S_DONE;
          end
          REQ_ALLOC: begin
            state_d = S_SCAN;
          end
          REQ_RESOLVE: begin
            if (sts_i.bad_id) begin
              cmd_o.load_res = 1'b1;
              cmd_o.res_sel  = RES_BAD;
              state_d        = S_DONE;
            end else begin
              cmd_o.rd_en = 1'b1;
              state_d     = S_RRES;
            end
          end
          default: begin
            cmd_o.load_res = 1'b1;
            state_d        = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        // read of slot cnt overlaps the check of the slot read last cycle
        cmd_o.rd_en   = issue;
        cmd_o.rd_scan = 1'b1;
        chk_d         = issue;
        if (issue) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
        if (found) begin
          cmd_o.claim    = 1'b1;
          cmd_o.load_res = 1'b1;
          cmd_o.res_sel  = RES_ALLOC;
          state_d        = S_DONE;
        end else if (scan_end) begin
          cmd_o.load_res = 1'b1;
          cmd_o.res_sel  = RES_FULL;
          state_d        = S_DONE;
        end
      end
      S_RRES: begin
        cmd_o.mark_done = 1'b1;
        cmd_o.load_res  = 1'b1;
        cmd_o.res_sel   = RES_RESOLVE;
        state_d         = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      chk_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      chk_q       <= chk_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[sv/request_id_translation_table_unit.sv]
`timescale 1ns / 1ps
// top level of the request id translation table
// depends on rid_pkg, rid_ctrl, rid_datapath
//
//   channel  direction  handshake                fields
//   in       input      in_valid_i / in_stall_o  req_type, txn_id, client_ip, client_port
//   out      output     out_valid_o / out_stall_i status, new_id, orig_id, client_ip_out,
//                                                client_port_out
//   cfg      input      cfg_we_i                 timeout_ticks (cfg_wdata_i)
//
// one transaction at a time: tick and unused types finish at dispatch, resolve reads its slot
// unless the id is bad, allocate scans from slot 0 until a reusable slot is claimed or the
// table is found full, the slot ram read port scanning one slot a cycle
// no clearing pass after reset: per-slot written and done flags reset at once
// a finished result waits in the output register while the next transaction is accepted

module request_id_translation_table_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] txn_id_i,
  input  logic [31:0] client_ip_i,
  input  logic [15:0] client_port_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [15:0] new_id_o,
  output logic [15:0] orig_id_o,
  output logic [31:0] client_ip_out_o,
  output logic [15:0] client_port_out_o
);

  import rid_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  rid_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rid_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .req_type_i       (req_type_i),
    .txn_id_i         (txn_id_i),
    .client_ip_i      (client_ip_i),
    .client_port_i    (client_port_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .status_o         (status_o),
    .new_id_o         (new_id_o),
    .orig_id_o        (orig_id_o),
    .client_ip_out_o  (client_ip_out_o),
    .client_port_out_o(client_port_out_o)
  );

endmodule

[sv/rid_checker.sv]
`timescale 1ns / 1ps
// port level checks of the request id translation table, bound to the top level
// depends on rid_pkg and request_id_translation_table_unit

module rid_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [15:0] new_id_o,
  input logic [15:0] orig_id_o,
  input logic [31:0] client_ip_out_o,
  input logic [15:0] client_port_out_o
);

  import rid_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(new_id_o))
    else $error("stalled result changed");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("transaction accepted while one is in flight");

  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |->
      (new_id_o == 16'd0) && (orig_id_o == 16'd0) && (client_ip_out_o == 32'd0))
    else $error("table full result carries data");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_BAD_ID) |->
      (new_id_o == 16'd0) && (orig_id_o == 16'd0) && (client_port_out_o == 16'd0))
    else $error("bad id result carries data");

  a_new_id_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (new_id_o != 16'd0) |->
      (status_o == ST_OK) && (new_id_o <= 16'(SLOTS)) && (orig_id_o == 16'd0))
    else $error("new id out of slot range");

endmodule

bind request_id_translation_table_unit rid_checker u_rid_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .status_o         (status_o),
  .new_id_o         (new_id_o),
  .orig_id_o        (orig_id_o),
  .client_ip_out_o  (client_ip_out_o),
  .client_port_out_o(client_port_out_o)
);

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// self-checking testbench for the request id translation table: directed and random
// transactions checked against a behavioral model of the table; depends on rid_pkg and the unit

module tb_top;
  import rid_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] new_id;
    logic [15:0] orig_id;
    logic [31:0] client_ip;
    logic [15:0] client_port;
  } answer_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [1:0]  req_type_i    = REQ_TICK;
  logic [15:0] txn_id_i      = '0;
  logic [31:0] client_ip_i   = '0;
  logic [15:0] client_port_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [15:0] new_id_o;
  logic [15:0] orig_id_o;
  logic [31:0] client_ip_out_o;
  logic [15:0] client_port_out_o;

  // table model
  logic [15:0] tbl_timeout;
  logic [31:0] tbl_now;
  logic [15:0] tbl_orig_id [SLOTS];
  logic [31:0] tbl_ip      [SLOTS];
  logic [15:0] tbl_port    [SLOTS];
  logic        tbl_done    [SLOTS];
  logic [31:0] tbl_expiry  [SLOTS];

  answer_t     pending_answers[$];
  logic [15:0] live_ids[$];
  int          fail_count = 0;
  int          stall_left = 0;
  bit          tx_calm    = 1'b0;
  bit          rx_calm    = 1'b0;

  request_id_translation_table_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type_i),
    .txn_id_i         (txn_id_i),
    .client_ip_i      (client_ip_i),
    .client_port_i    (client_port_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .new_id_o         (new_id_o),
    .orig_id_o        (orig_id_o),
    .client_ip_out_o  (client_ip_out_o),
    .client_port_out_o(client_port_out_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic predict_answer(input logic [1:0] rt, input logic [15:0] id,
                                input logic [31:0] ip, input logic [15:0] port);
    answer_t     a;
    logic [32:0] sum;
    bit          claimed;
    a = '{ST_OK, 16'd0, 16'd0, 32'd0, 16'd0};
    claimed = 1'b0;
    case (rt)
      REQ_TICK: begin
        if (tbl_now != TIME_MAX) tbl_now = tbl_now + 32'd1;
      end
      REQ_ALLOC: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!claimed && (i + 1 != int'(id)) &&
              (tbl_done[i] || (tbl_expiry[i] != 32'd0 && tbl_expiry[i] < tbl_now))) begin
            claimed        = 1'b1;
            tbl_orig_id[i] = id;
            tbl_ip[i]      = ip;
            tbl_port[i]    = port;
            tbl_done[i]    = 1'b0;
            sum            = {1'b0, tbl_now} + {17'd0, tbl_timeout};
            tbl_expiry[i]  = sum[32] ? TIME_MAX : sum[31:0];
            a.new_id       = 16'(i + 1);
          end
        end
        if (claimed) live_ids.push_back(a.new_id);
        else a.status = ST_FULL;
      end
      REQ_RESOLVE: begin
        if (id == 16'd0 || int'(id) > SLOTS) begin
          a.status = ST_BAD_ID;
        end else begin
          tbl_done[id - 1] = 1'b1;
          a.orig_id        = tbl_orig_id[id - 1];
          a.client_ip      = tbl_ip[id - 1];
          a.client_port    = tbl_port[id - 1];
        end
      end
      default: ;
    endcase
    pending_answers.push_back(a);
  endtask

  task automatic send_req(input logic [1:0] rt, input logic [15:0] id,
                          input logic [31:0] ip, input logic [15:0] port);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= rt;
    txn_id_i      <= id;
    client_ip_i   <= ip;
    client_port_i <= port;
    do @(posedge clk_i); while (in_stall_o);
    predict_answer(rt, id, ip, port);
  endtask

  // hold off the sender until every answer is back and the unit has gone quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (SLOTS + 8) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [15:0] value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    tbl_timeout = value;
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    answer_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_answers.size() == 0) begin
        $error("result with no pending transaction");
        fail_count++;
      end else begin
        want = pending_answers.pop_front();
        check_field("status", 32'(want.status), 32'(status_o));
        check_field("new_id", 32'(want.new_id), 32'(new_id_o));
        check_field("orig_id", 32'(want.orig_id), 32'(orig_id_o));
        check_field("client_ip_out", want.client_ip, client_ip_out_o);
        check_field("client_port_out", 32'(want.client_port), 32'(client_port_out_o));
      end
      stall_left = rx_calm ? 0 : $urandom_range(0, 7);
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall_i <= (stall_left != 0);
  end

  task automatic test_directed();
    send_req(REQ_RESOLVE, 16'd1, 32'd0, 16'd0);
    send_req(REQ_RESOLVE, 16'd0, 32'd0, 16'd0);
    send_req(REQ_RESOLVE, 16'(SLOTS + 1), 32'd0, 16'd0);
    send_req(REQ_RESOLVE, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_req(REQ_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_req(REQ_TICK, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    // slot 0 would hand back the incoming id, so it is skipped
    send_req(REQ_ALLOC, 16'd1, 32'hFFFF_FFFF, 16'hFFFF);
    send_req(REQ_ALLOC, 16'hFFFF, 32'd0, 16'd0);
    send_req(REQ_ALLOC, 16'd0, 32'hA5C3_0F96, 16'h5A3C);
    send_req(REQ_RESOLVE, 16'd2, 32'd0, 16'd0);
    send_req(REQ_RESOLVE, 16'(SLOTS), 32'd0, 16'd0);
    repeat (7) send_req(REQ_TICK, 16'd0, 32'd0, 16'd0);
    // resolved and expired slots come back
    send_req(REQ_ALLOC, 16'd1, 32'h0102_0304, 16'd53);
    send_req(REQ_ALLOC, 16'd3, 32'hC0A8_0001, 16'd1024);
  endtask

  task automatic test_zero_timeout();
    write_timeout(16'd0);
    send_req(REQ_ALLOC, 16'h1234, 32'h0A00_0001, 16'd5353);
    send_req(REQ_ALLOC, 16'h4321, 32'h0A00_0002, 16'd5354);
    send_req(REQ_TICK, 16'd0, 32'd0, 16'd0);
    send_req(REQ_ALLOC, 16'h5555, 32'h0A00_0003, 16'd5355);
    send_req(REQ_RESOLVE, 16'd1, 32'd0, 16'd0);
  endtask

  task automatic test_random_traffic(input int count, input logic [15:0] timeout,
                                     input int alloc_pct);
    int          pick;
    int          k;
    logic [1:0]  rt;
    logic [15:0] id;
    write_timeout(timeout);
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        tx_calm = ($urandom_range(0, 3) == 0);
        rx_calm = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      id   = 16'($urandom);
      if (pick < alloc_pct) begin
        rt = REQ_ALLOC;
        if ($urandom_range(0, 3) == 0) id = 16'($urandom_range(0, SLOTS + 1));
      end else if (pick < alloc_pct + 25) begin
        rt = REQ_RESOLVE;
        if (live_ids.size() != 0 && $urandom_range(0, 4) != 0) begin
          k  = $urandom_range(0, live_ids.size() - 1);
          id = live_ids[k];
          live_ids.delete(k);
        end else if ($urandom_range(0, 1) == 0) begin
          id = 16'($urandom_range(0, SLOTS + 2));
        end
      end else if (pick < 97) begin
        rt = REQ_TICK;
      end else begin
        rt = REQ_UNUSED;
      end
      send_req(rt, id, $urandom, 16'($urandom));
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  initial begin
    tbl_timeout = TIMEOUT_RESET;
    tbl_now     = '0;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_orig_id[i] = '0;
      tbl_ip[i]      = '0;
      tbl_port[i]    = '0;
      tbl_done[i]    = 1'b1;
      tbl_expiry[i]  = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_zero_timeout();
    test_random_traffic(110, 16'd1, 40);
    test_random_traffic(110, 16'hFFFF, 60);
    test_random_traffic(110, 16'($urandom_range(2, 200)), 40);
    test_random_traffic(110, 16'd0, 35);
    test_random_traffic(110, TIMEOUT_RESET, 45);
    settle();
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
